// File: rtl/ftidp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ftidp_pkg;

   // fixed field widths at the ports
   localparam int KIND_W   = 2;
   localparam int COUNT_W  = 11;
   localparam int INDEX_W  = 16;
   localparam int FIDX_W   = 10;
   localparam int TRACK_W  = 32;

   // width of the per-entry frame tags that stand in for the clear of
   // the link and used marks
   localparam int EPOCH_W  = 8;

   localparam logic [KIND_W-1:0] KIND_BEGIN   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FEATURE = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } ftidp_state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic sweep;
   } ftidp_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic wrap;
   } ftidp_status_type;

endpackage

`default_nettype wire

// File: rtl/ftidp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ftidp_ctrl
   import ftidp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output ftidp_cmd_type         cmd,
   input  wire ftidp_status_type status
);

   ftidp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // tag wrap on a begin: scrub that class before the next transfer
            state_in = status.wrap ? ST_CLEAR : ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      busy        = 1'b1;
      cmd.capture = 1'b0;
      cmd.exec    = 1'b0;
      cmd.sweep   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
         end
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_READ: begin
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/ftidp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ftidp_datapath
   import ftidp_pkg::*;
#(
   parameter int MAX_FEATURES = 1024,
   parameter int ID_WIDTH     = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ftidp_cmd_type             cmd,
   output ftidp_status_type               status,
   input  wire logic [KIND_W-1:0]         req_kind,
   input  wire logic                      req_track_class,
   input  wire logic [COUNT_W-1:0]        req_feature_count,
   input  wire logic signed [INDEX_W-1:0] req_prev_index,
   input  wire logic signed [INDEX_W-1:0] req_curr_index,
   output logic                           rsp_valid,
   output logic [FIDX_W-1:0]              rsp_feature_index,
   output logic [TRACK_W-1:0]             rsp_track_id,
   output logic                           rsp_is_new,
   output logic                           rsp_last_of_frame
);

   localparam int IDX_W     = $clog2(MAX_FEATURES);
   localparam int CNT_W     = $clog2(MAX_FEATURES + 1);
   localparam int CLP_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int CMP_W     = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int TAG_DEPTH = 2 ** (IDX_W + 1);
   localparam int ID_DEPTH  = 2 ** (IDX_W + 2);

   // captured item
   logic [KIND_W-1:0]   kind_ff;
   logic                cls_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [INDEX_W-1:0]  prev_ff;
   logic [INDEX_W-1:0]  curr_ff;

   // per-class frame state
   logic [CNT_W-1:0]    size_ff   [2];
   logic [CNT_W-1:0]    size_in   [2];
   logic [CNT_W-1:0]    pos_ff    [2];
   logic [CNT_W-1:0]    pos_in    [2];
   logic [CNT_W-1:0]    pcount_ff [2];
   logic [CNT_W-1:0]    pcount_in [2];
   logic                bank_ff   [2];
   logic                bank_in   [2];
   logic [EPOCH_W-1:0]  epoch_ff  [2];
   logic [EPOCH_W-1:0]  epoch_in  [2];
   logic [ID_WIDTH-1:0] next_track_ff, next_track_in;

   logic [IDX_W:0]      sweep_addr_ff, sweep_addr_in;
   logic                sweep_all_ff, sweep_all_in;

   // memories: link tags, used tags, ID maps (two banks per class, swapped on close)
   logic [EPOCH_W-1:0]  valid_mem [TAG_DEPTH];
   logic [EPOCH_W-1:0]  used_mem  [TAG_DEPTH];
   logic [ID_WIDTH-1:0] id_mem    [ID_DEPTH];
   logic [EPOCH_W-1:0]  valid_tag_ff;
   logic [EPOCH_W-1:0]  used_tag_ff;
   logic [ID_WIDTH-1:0] id_rd_ff;

   logic                rsp_valid_ff;
   logic [FIDX_W-1:0]   rsp_index_ff;
   logic [TRACK_W-1:0]  rsp_id_ff;
   logic                rsp_new_ff;
   logic                rsp_last_ff;

   logic [CNT_W-1:0]    cur_size, cur_pos, cur_pcount, pos_next, begin_n;
   logic                cur_bank;
   logic [EPOCH_W-1:0]  cur_epoch;
   logic [IDX_W-1:0]    prev_idx, curr_idx, pos_idx;
   logic [IDX_W:0]      valid_raddr, used_raddr;
   logic [IDX_W+1:0]    id_raddr, id_waddr;
   logic                valid_hit, used_hit, match_ok, feat_ok, last;
   logic                is_begin, is_match, is_feature;
   logic                valid_we, used_we, id_we;
   logic [IDX_W:0]      valid_waddr, used_waddr;
   logic [EPOCH_W-1:0]  tag_wdata;
   logic [ID_WIDTH-1:0] id_wdata, feat_id;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         cls_ff   <= req_track_class;
         count_ff <= req_feature_count;
         prev_ff  <= $unsigned(req_prev_index);
         curr_ff  <= $unsigned(req_curr_index);
      end
   end

   assign is_begin   = (kind_ff == KIND_BEGIN);
   assign is_match   = (kind_ff == KIND_MATCH);
   assign is_feature = (kind_ff == KIND_FEATURE);

   assign cur_size   = size_ff[cls_ff];
   assign cur_pos    = pos_ff[cls_ff];
   assign cur_pcount = pcount_ff[cls_ff];
   assign cur_bank   = bank_ff[cls_ff];
   assign cur_epoch  = epoch_ff[cls_ff];

   assign prev_idx = IDX_W'(prev_ff);
   assign curr_idx = IDX_W'(curr_ff);
   assign pos_idx  = IDX_W'(cur_pos);

   assign valid_raddr = {cls_ff, is_feature ? pos_idx : curr_idx};
   assign used_raddr  = {cls_ff, prev_idx};
   assign id_raddr    = is_match ? {cls_ff, ~cur_bank, prev_idx}
                                 : {cls_ff, cur_bank, pos_idx};

   assign valid_hit = (valid_tag_ff == cur_epoch);
   assign used_hit  = (used_tag_ff == cur_epoch);

   assign match_ok = is_match && (cur_pos == '0)
                     && !prev_ff[INDEX_W-1] && !curr_ff[INDEX_W-1]
                     && (CMP_W'(curr_ff) < CMP_W'(cur_size))
                     && (CMP_W'(prev_ff) < CMP_W'(cur_pcount))
                     && !used_hit;
   assign feat_ok  = is_feature && (cur_pos < cur_size);
   assign pos_next = cur_pos + 1'b1;
   assign last     = (pos_next == cur_size);
   assign feat_id  = valid_hit ? id_rd_ff : next_track_ff;
   assign begin_n  = (CLP_W'(count_ff) > CLP_W'(MAX_FEATURES)) ? CNT_W'(MAX_FEATURES)
                                                              : CNT_W'(count_ff);

   // memory write side
   assign used_we     = cmd.sweep || (cmd.exec && match_ok);
   assign valid_we    = cmd.sweep || (cmd.exec && match_ok && !valid_hit);
   assign used_waddr  = cmd.sweep ? sweep_addr_ff : used_raddr;
   assign valid_waddr = cmd.sweep ? sweep_addr_ff : valid_raddr;
   assign tag_wdata   = cmd.sweep ? '0 : cur_epoch;
   assign id_we       = cmd.exec && !valid_hit && (match_ok || feat_ok);
   assign id_waddr    = {cls_ff, cur_bank, is_match ? curr_idx : pos_idx};
   assign id_wdata    = is_match ? id_rd_ff : next_track_ff;

   always_ff @(posedge clock) begin
      if (valid_we) begin
         valid_mem[valid_waddr] <= tag_wdata;
      end
      valid_tag_ff <= valid_mem[valid_raddr];
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_waddr] <= tag_wdata;
      end
      used_tag_ff <= used_mem[used_raddr];
   end

   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[id_waddr] <= id_wdata;
      end
      id_rd_ff <= id_mem[id_raddr];
   end

   // sweep: whole tag space after reset, one class after its tag wraps
   assign status.sweep_last = (sweep_addr_ff[IDX_W-1:0] == '1)
                              && (!sweep_all_ff || sweep_addr_ff[IDX_W]);
   assign status.wrap       = is_begin && (cur_epoch == '1);

   always_comb begin
      size_in       = size_ff;
      pos_in        = pos_ff;
      pcount_in     = pcount_ff;
      bank_in       = bank_ff;
      epoch_in      = epoch_ff;
      next_track_in = next_track_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_all_in  = sweep_all_ff;
      if (cmd.sweep) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
      end
      if (cmd.exec) begin
         case (kind_ff)
            KIND_BEGIN: begin
               size_in[cls_ff] = begin_n;
               pos_in[cls_ff]  = '0;
               if (cur_epoch == '1) begin
                  // tag 0 marks scrubbed entries
                  epoch_in[cls_ff] = EPOCH_W'(1);
                  sweep_addr_in    = {cls_ff, {IDX_W{1'b0}}};
                  sweep_all_in     = 1'b0;
               end else begin
                  epoch_in[cls_ff] = cur_epoch + 1'b1;
               end
               if (begin_n == '0) begin
                  pcount_in[cls_ff] = '0;
                  bank_in[cls_ff]   = ~cur_bank;
               end
            end
            KIND_FEATURE: begin
               if (feat_ok) begin
                  if (!valid_hit) begin
                     next_track_in = next_track_ff + 1'b1;
                  end
                  if (last) begin
                     pcount_in[cls_ff] = cur_size;
                     size_in[cls_ff]   = '0;
                     pos_in[cls_ff]    = '0;
                     bank_in[cls_ff]   = ~cur_bank;
                  end else begin
                     pos_in[cls_ff] = pos_next;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 2; c++) begin
            size_ff[c]   <= '0;
            pos_ff[c]    <= '0;
            pcount_ff[c] <= '0;
            bank_ff[c]   <= 1'b0;
            epoch_ff[c]  <= EPOCH_W'(1);
         end
         next_track_ff <= '0;
         sweep_addr_ff <= '0;
         sweep_all_ff  <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         size_ff       <= size_in;
         pos_ff        <= pos_in;
         pcount_ff     <= pcount_in;
         bank_ff       <= bank_in;
         epoch_ff      <= epoch_in;
         next_track_ff <= next_track_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_all_ff  <= sweep_all_in;
         rsp_valid_ff  <= cmd.exec && feat_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && feat_ok) begin
         rsp_index_ff <= FIDX_W'(cur_pos);
         rsp_id_ff    <= TRACK_W'(feat_id);
         rsp_new_ff   <= !valid_hit;
         rsp_last_ff  <= last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_feature_index = rsp_index_ff;
   assign rsp_track_id      = rsp_id_ff;
   assign rsp_is_new        = rsp_new_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/feature_track_id_propagator_core.sv
// Results: a feature's result is strobed on rsp_valid for one cycle, registered out of the
// evaluate state that follows its table read; begin and match items give none.
// Flow: one item at a time; the next transfer waits until capture, table read, evaluate and write are done.
// Reset: busy stays high while the whole tag space of both classes is scrubbed; every
// 255th begin of a class scrubs the tags of that class, with busy high meanwhile.
// The receiver cannot stall: each result is taken in its strobe cycle.
`timescale 1ns / 1ps
`default_nettype none

module feature_track_id_propagator_core
   import ftidp_pkg::*;
#(
   parameter int MAX_FEATURES = 1024,
   parameter int ID_WIDTH     = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [KIND_W-1:0]         req_kind,
   input  wire logic                      req_track_class,
   input  wire logic [COUNT_W-1:0]        req_feature_count,
   input  wire logic signed [INDEX_W-1:0] req_prev_index,
   input  wire logic signed [INDEX_W-1:0] req_curr_index,
   output logic                           rsp_valid,
   output logic [FIDX_W-1:0]              rsp_feature_index,
   output logic [TRACK_W-1:0]             rsp_track_id,
   output logic                           rsp_is_new,
   output logic                           rsp_last_of_frame
);

   ftidp_cmd_type    cmd;
   ftidp_status_type status;

   ftidp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   ftidp_datapath #(
      .MAX_FEATURES (MAX_FEATURES),
      .ID_WIDTH     (ID_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_track_class   (req_track_class),
      .req_feature_count (req_feature_count),
      .req_prev_index    (req_prev_index),
      .req_curr_index    (req_curr_index),
      .rsp_valid         (rsp_valid),
      .rsp_feature_index (rsp_feature_index),
      .rsp_track_id      (rsp_track_id),
      .rsp_is_new        (rsp_is_new),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

`default_nettype wire
